/* rtl/core/strict_priority_multi_queue_assert.svh */
// Assertion helpers for the queue RTL, included by spmq_back.
`ifndef STRICT_PRIORITY_MULTI_QUEUE_ASSERT_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPMQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/spmq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package spmq_pkg;

	localparam int LEVELS      = 8;
	localparam int LEVEL_DEPTH = 16;
	localparam int ID_BITS     = 16;

	localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int POS_W       = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
	localparam int TOTAL_SLOTS = LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
	localparam int TOT_W       = $clog2(TOTAL_SLOTS + 1);

	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QFILL_W     = $clog2(QDEPTH + 1);

	localparam logic [2:0] ACT_ENQ    = 3'd0;
	localparam logic [2:0] ACT_DEQ    = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_FIND   = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef enum logic [2:0] {
		OP_ENQ,
		OP_DEQ,
		OP_REMOVE,
		OP_FIND,
		OP_CLEAR,
		OP_BADPRI,
		OP_NOP
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t            op;
		logic [ID_BITS-1:0] id;
		logic [LVL_W-1:0]   lvl;
	} cmd_t;

	function automatic logic [ADDR_W-1:0] slot_addr(logic [LVL_W-1:0] l, logic [CNT_W-1:0] p);
		return ADDR_W'(l) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(p[POS_W-1:0]);
	endfunction

	function automatic logic [15:0] id_to_port(logic [ID_BITS-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[15:0];
	endfunction

	function automatic logic [2:0] lvl_to_port(logic [LVL_W-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[2:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/core/spmq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module spmq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/spmq_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module spmq_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [15:0] item_id,
	input  wire logic [3:0]  priority_req,
	output spmq_pkg::cmd_t   cmd,
	output logic             cmd_valid,
	input  wire logic        cmd_take
);

	spmq_pkg::cmd_t                       slot_q [spmq_pkg::QDEPTH];
	logic [spmq_pkg::QPTR_W-1:0]          wp_q;
	logic [spmq_pkg::QPTR_W-1:0]          rp_q;
	logic [spmq_pkg::QFILL_W-1:0]         fill_q;
	spmq_pkg::cmd_t                       in_cmd;
	logic                                 push;
	logic                                 pop;

	// Classify the request before it is queued.
	always_comb begin
		in_cmd.id  = spmq_pkg::ID_BITS'(item_id);
		in_cmd.lvl = spmq_pkg::LVL_W'(priority_req);
		unique case (action)
			spmq_pkg::ACT_ENQ: begin
				in_cmd.op = (32'(priority_req) >= spmq_pkg::LEVELS)
					? spmq_pkg::OP_BADPRI : spmq_pkg::OP_ENQ;
			end
			spmq_pkg::ACT_DEQ:    in_cmd.op = spmq_pkg::OP_DEQ;
			spmq_pkg::ACT_REMOVE: in_cmd.op = spmq_pkg::OP_REMOVE;
			spmq_pkg::ACT_FIND:   in_cmd.op = spmq_pkg::OP_FIND;
			spmq_pkg::ACT_CLEAR:  in_cmd.op = spmq_pkg::OP_CLEAR;
			default:              in_cmd.op = spmq_pkg::OP_NOP;
		endcase
	end

	assign in_stall  = (fill_q == spmq_pkg::QFILL_W'(spmq_pkg::QDEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = slot_q[rp_q];
	assign push      = in_valid && !in_stall;
	assign pop       = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == spmq_pkg::QPTR_W'(spmq_pkg::QDEPTH - 1))
					? '0 : wp_q + spmq_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == spmq_pkg::QPTR_W'(spmq_pkg::QDEPTH - 1))
					? '0 : rp_q + spmq_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + spmq_pkg::QFILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - spmq_pkg::QFILL_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/spmq_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "strict_priority_multi_queue_assert.svh"
module spmq_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire spmq_pkg::cmd_t  cmd,
	input  wire logic            cmd_valid,
	output logic                 cmd_take,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [1:0]           status,
	output logic [15:0]          out_id,
	output logic [2:0]           out_level,
	output logic [7:0]           total_count,
	output logic                 all_empty
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	localparam int LVL_W = spmq_pkg::LVL_W;
	localparam int CNT_W = spmq_pkg::CNT_W;
	localparam int TOT_W = spmq_pkg::TOT_W;

	state_t                          state_q;
	spmq_pkg::cmd_t                  cur_q;
	logic [CNT_W-1:0]                cnt_q [spmq_pkg::LEVELS];
	logic [TOT_W-1:0]                total_q;
	logic [LVL_W-1:0]                sc_lvl_q;
	logic [CNT_W-1:0]                sc_pos_q;
	logic                            sc_end_q;
	logic                            rd_vld_s1;
	logic [LVL_W-1:0]                rd_lvl_s1;
	logic [CNT_W-1:0]                rd_pos_s1;
	logic [LVL_W-1:0]                sh_lvl_q;
	logic [CNT_W-1:0]                sh_src_q;
	logic                            sh_pend_s1;
	logic [CNT_W-1:0]                sh_src_s1;
	logic                            out_valid_q;
	logic [1:0]                      status_q;
	logic [15:0]                     out_id_q;
	logic [2:0]                      out_lvl_q;

	logic                            out_free;
	logic                            match;
	logic                            scan_issue;
	logic                            shift_issue;
	logic                            rd_en;
	logic [spmq_pkg::ADDR_W-1:0]     rd_addr;
	logic [spmq_pkg::ID_BITS-1:0]    rd_data;
	logic                            wr_en;
	logic [spmq_pkg::ADDR_W-1:0]     wr_addr;
	logic [spmq_pkg::ID_BITS-1:0]    wr_data;
	logic                            enq_room;

	assign out_free    = !out_valid_q || !out_stall;
	assign cmd_take    = (state_q == S_IDLE) && cmd_valid && out_free;
	assign enq_room    = cnt_q[cmd.lvl] < CNT_W'(spmq_pkg::LEVEL_DEPTH);
	// Dequeue matches whatever the first non-empty level holds at its head.
	assign match       = (state_q == S_SCAN) && rd_vld_s1
		&& (cur_q.op == spmq_pkg::OP_DEQ || rd_data == cur_q.id);
	assign scan_issue  = (state_q == S_SCAN) && !sc_end_q && !match
		&& (sc_pos_q < cnt_q[sc_lvl_q]);
	assign shift_issue = (state_q == S_SHIFT) && (sh_src_q < cnt_q[sh_lvl_q]);

	always_comb begin
		rd_en   = scan_issue || shift_issue;
		rd_addr = scan_issue ? spmq_pkg::slot_addr(sc_lvl_q, sc_pos_q)
			: spmq_pkg::slot_addr(sh_lvl_q, sh_src_q);
		if (state_q == S_SHIFT) begin
			wr_en   = sh_pend_s1;
			wr_addr = spmq_pkg::slot_addr(sh_lvl_q, sh_src_s1 - CNT_W'(1));
			wr_data = rd_data;
		end else begin
			wr_en   = cmd_take && (cmd.op == spmq_pkg::OP_ENQ) && enq_room;
			wr_addr = spmq_pkg::slot_addr(cmd.lvl, cnt_q[cmd.lvl]);
			wr_data = cmd.id;
		end
	end

	spmq_ram #(
		.WIDTH (spmq_pkg::ID_BITS),
		.DEPTH (spmq_pkg::TOTAL_SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '{default: '0};
			total_q     <= '0;
			sc_end_q    <= 1'b0;
			rd_vld_s1   <= 1'b0;
			sh_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						cur_q     <= cmd;
						out_id_q  <= '0;
						out_lvl_q <= '0;
						unique case (cmd.op)
							spmq_pkg::OP_ENQ: begin
								out_valid_q <= 1'b1;
								if (enq_room) begin
									cnt_q[cmd.lvl] <= cnt_q[cmd.lvl] + CNT_W'(1);
									total_q        <= total_q + TOT_W'(1);
									status_q       <= spmq_pkg::ST_OK;
								end else begin
									status_q <= spmq_pkg::ST_FULL;
								end
							end
							spmq_pkg::OP_BADPRI: begin
								out_valid_q <= 1'b1;
								status_q    <= spmq_pkg::ST_RANGE;
							end
							spmq_pkg::OP_CLEAR: begin
								out_valid_q <= 1'b1;
								status_q    <= spmq_pkg::ST_OK;
								cnt_q       <= '{default: '0};
								total_q     <= '0;
							end
							spmq_pkg::OP_DEQ, spmq_pkg::OP_REMOVE, spmq_pkg::OP_FIND: begin
								out_valid_q <= 1'b0;
								status_q    <= spmq_pkg::ST_OK;
								sc_lvl_q    <= '0;
								sc_pos_q    <= '0;
								sc_end_q    <= 1'b0;
								rd_vld_s1   <= 1'b0;
								state_q     <= S_SCAN;
							end
							default: begin
								out_valid_q <= 1'b1;
								status_q    <= spmq_pkg::ST_OK;
							end
						endcase
					end else if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				S_SCAN: begin
					rd_vld_s1 <= scan_issue;
					rd_lvl_s1 <= sc_lvl_q;
					rd_pos_s1 <= sc_pos_q;
					if (scan_issue) begin
						sc_pos_q <= sc_pos_q + CNT_W'(1);
					end else if (!sc_end_q) begin
						if (sc_lvl_q == LVL_W'(spmq_pkg::LEVELS - 1)) begin
							sc_end_q <= 1'b1;
						end else begin
							sc_lvl_q <= sc_lvl_q + LVL_W'(1);
							sc_pos_q <= '0;
						end
					end
					if (match) begin
						out_id_q  <= spmq_pkg::id_to_port(rd_data);
						out_lvl_q <= spmq_pkg::lvl_to_port(rd_lvl_s1);
						if (cur_q.op == spmq_pkg::OP_FIND) begin
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							sh_lvl_q   <= rd_lvl_s1;
							sh_src_q   <= rd_pos_s1 + CNT_W'(1);
							sh_pend_s1 <= 1'b0;
							state_q    <= S_SHIFT;
						end
					end else if (!rd_vld_s1 && sc_end_q) begin
						status_q    <= spmq_pkg::ST_NONE;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_SHIFT: begin
					// Move each later entry down one slot to close the gap.
					sh_pend_s1 <= shift_issue;
					sh_src_s1  <= sh_src_q;
					if (shift_issue) begin
						sh_src_q <= sh_src_q + CNT_W'(1);
					end
					if (!sh_pend_s1 && !shift_issue) begin
						cnt_q[sh_lvl_q] <= cnt_q[sh_lvl_q] - CNT_W'(1);
						total_q         <= total_q - TOT_W'(1);
						out_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_id      = out_id_q;
	assign out_level   = out_lvl_q;
	assign total_count = (total_q > TOT_W'(255)) ? 8'd255 : 8'(total_q);
	assign all_empty   = (total_q == '0);

	`SPMQ_ASSERT_IMPL(a_total_bound, clk, arst_n, 1'b1, total_q <= TOT_W'(spmq_pkg::TOTAL_SLOTS), "total count beyond capacity")
	`SPMQ_ASSERT_IMPL(a_shift_nonempty, clk, arst_n, state_q == S_SHIFT, cnt_q[sh_lvl_q] != '0, "shift on an empty level")
	`SPMQ_ASSERT_IMPL(a_no_write_in_scan, clk, arst_n, state_q == S_SCAN, !wr_en, "store written during a search")
	`SPMQ_ASSERT_IMPL(a_busy_out_free, clk, arst_n, state_q != S_IDLE, !out_valid_q, "result pending while busy")
	`SPMQ_ASSERT_NEXT(a_enq_one_cycle, clk, arst_n, cmd_take && cmd.op == spmq_pkg::OP_ENQ, out_valid_q && state_q == S_IDLE, "enqueue result missing")

endmodule
`default_nettype wire

/* rtl/core/strict_priority_multi_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// Strict-priority multi-level queue of item identifiers.
// Input channel (in_valid / in_stall) carries action, item_id and priority_req;
// a transfer happens on a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall) returns one result per request:
// status, out_id, out_level, total_count and all_empty.
// Requests pass a two-entry command queue before the execution engine, so the
// input side keeps taking requests while the engine is busy, until it fills.
// Enqueue, clear, invalid priority and unknown actions complete one per cycle
// while the receiver does not stall. Dequeue, remove and find walk the levels
// through the single read port of the entry store, entry by entry and level by
// level; remove and dequeue then compact the level at one entry a cycle. One
// request is executed at a time.
// While the receiver stalls, the result is held and the engine waits; the
// command queue fills and then raises in_stall.
// Reset empties every level and the command queue; the entry store needs
// no clearing pass.
module strict_priority_multi_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [15:0] item_id,
	input  wire logic [3:0]  priority_req,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [15:0]      out_id,
	output logic [2:0]       out_level,
	output logic [7:0]       total_count,
	output logic             all_empty
);

	spmq_pkg::cmd_t cmd;
	logic           cmd_valid;
	logic           cmd_take;

	spmq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.item_id      (item_id),
		.priority_req (priority_req),
		.cmd          (cmd),
		.cmd_valid    (cmd_valid),
		.cmd_take     (cmd_take)
	);

	spmq_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cmd_valid   (cmd_valid),
		.cmd_take    (cmd_take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_id      (out_id),
		.out_level   (out_level),
		.total_count (total_count),
		.all_empty   (all_empty)
	);

endmodule
`default_nettype wire
